>>> rtl/fpr_pkg.sv
// fpr_pkg: types and fixed widths shared by the file peer registry.
// No dependencies; compiled first.
package fpr_pkg;

    localparam int HASH_W  = 64;
    localparam int CHUNK_W = 32;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int STAT_W  = 3;
    localparam int INDEX_W = 6;
    localparam int TOTAL_W = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_CREATED    = 3'd0,
        ST_ADDED      = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_LIST_FULL  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    // announcement travelling down the cell row
    typedef struct packed {
        logic [HASH_W-1:0]  hash_word0;
        logic [HASH_W-1:0]  hash_word1;
        logic [HASH_W-1:0]  hash_word2;
        logic [HASH_W-1:0]  hash_word3;
        logic [CHUNK_W-1:0] chunk_count;
        logic [ADDR_W-1:0]  peer_address;
        logic [PORT_W-1:0]  peer_port;
    } t_probe;

    // resolution carried along with the probe
    typedef struct packed {
        logic    done;
        t_status status;
    } t_res;

endpackage

>>> rtl/fpr_if.sv
// fpr_if: valid/ready channel interfaces for announcements and results.
// Depends on fpr_pkg for field widths.
interface fpr_ann_if;
    logic                          valid;
    logic                          ready;
    logic [fpr_pkg::HASH_W-1:0]    hash_word0;
    logic [fpr_pkg::HASH_W-1:0]    hash_word1;
    logic [fpr_pkg::HASH_W-1:0]    hash_word2;
    logic [fpr_pkg::HASH_W-1:0]    hash_word3;
    logic [fpr_pkg::CHUNK_W-1:0]   chunk_count;
    logic [fpr_pkg::ADDR_W-1:0]    peer_address;
    logic [fpr_pkg::PORT_W-1:0]    peer_port;

    modport source (output valid, hash_word0, hash_word1, hash_word2, hash_word3,
                    chunk_count, peer_address, peer_port, input ready);
    modport sink   (input valid, hash_word0, hash_word1, hash_word2, hash_word3,
                    chunk_count, peer_address, peer_port, output ready);
endinterface

interface fpr_res_if;
    logic                          valid;
    logic                          ready;
    logic [fpr_pkg::STAT_W-1:0]    status;
    logic [fpr_pkg::INDEX_W-1:0]   entry_index;
    logic [fpr_pkg::TOTAL_W-1:0]   peer_total;

    modport source (output valid, status, entry_index, peer_total, input ready);
    modport sink   (input valid, status, entry_index, peer_total, output ready);
endinterface

>>> rtl/fpr_cell.sv
// fpr_cell: one table slot of the registry plus its peer list.
// Depends on fpr_pkg; instantiated in a row by file_peer_registry_unit.
module fpr_cell #(
    parameter int CELL_IDX = 0,
    parameter int PEERS    = 5,
    parameter int IW       = 6,
    parameter int CW       = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  fpr_pkg::t_probe  i_probe,
    input  fpr_pkg::t_res    i_res,
    input  logic [IW-1:0]    i_idx,
    input  logic [CW-1:0]    i_tot,
    output logic             o_vld,
    output fpr_pkg::t_probe  o_probe,
    output fpr_pkg::t_res    o_res,
    output logic [IW-1:0]    o_idx,
    output logic [CW-1:0]    o_tot
);

    logic                          r_valid;
    logic [CW-1:0]                 r_cnt;
    logic [fpr_pkg::HASH_W-1:0]    r_key0, r_key1, r_key2, r_key3;
    logic [fpr_pkg::CHUNK_W-1:0]   r_chunks;
    logic [fpr_pkg::ADDR_W-1:0]    r_paddr [PEERS];
    logic [fpr_pkg::PORT_W-1:0]    r_pport [PEERS];

    logic                          r_ovld;
    fpr_pkg::t_probe               r_oprobe;
    fpr_pkg::t_res                 r_ores;
    logic [IW-1:0]                 r_oidx;
    logic [CW-1:0]                 r_otot;

    logic                          w_hit, w_dup, w_add, w_create;
    fpr_pkg::t_res                 n_res;
    logic [IW-1:0]                 n_idx;
    logic [CW-1:0]                 n_tot;

    always_comb begin
        w_hit = r_valid
             && r_key0 == i_probe.hash_word0 && r_key1 == i_probe.hash_word1
             && r_key2 == i_probe.hash_word2 && r_key3 == i_probe.hash_word3;
        w_dup = 1'b0;
        for (int p = 0; p < PEERS; p++) begin
            if (CW'(p) < r_cnt && r_paddr[p] == i_probe.peer_address
                && r_pport[p] == i_probe.peer_port) begin
                w_dup = 1'b1;
            end
        end
    end

    always_comb begin
        n_res    = i_res;
        n_idx    = i_idx;
        n_tot    = i_tot;
        w_add    = 1'b0;
        w_create = 1'b0;
        if (!i_res.done) begin
            if (w_hit) begin
                n_res.done = 1'b1;
                n_idx      = IW'(CELL_IDX);
                priority if (w_dup) begin
                    n_res.status = fpr_pkg::ST_DUPLICATE;
                    n_tot        = r_cnt;
                end else if (r_cnt >= CW'(PEERS)) begin
                    n_res.status = fpr_pkg::ST_LIST_FULL;
                    n_tot        = r_cnt;
                end else begin
                    n_res.status = fpr_pkg::ST_ADDED;
                    n_tot        = r_cnt + CW'(1);
                    w_add        = 1'b1;
                end
            end else if (!r_valid) begin
                // slots fill from the bottom, so the first empty one ends the search
                n_res.done   = 1'b1;
                n_res.status = fpr_pkg::ST_CREATED;
                n_idx        = IW'(CELL_IDX);
                n_tot        = CW'(1);
                w_create     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else if (i_adv) begin
            r_ovld <= i_vld;
            if (i_vld && w_create) begin
                r_valid <= 1'b1;
                r_cnt   <= CW'(1);
            end else if (i_vld && w_add) begin
                r_cnt   <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oprobe <= i_probe;
            r_ores   <= n_res;
            r_oidx   <= n_idx;
            r_otot   <= n_tot;
            if (i_vld && w_create) begin
                r_key0     <= i_probe.hash_word0;
                r_key1     <= i_probe.hash_word1;
                r_key2     <= i_probe.hash_word2;
                r_key3     <= i_probe.hash_word3;
                r_chunks   <= i_probe.chunk_count;
                r_paddr[0] <= i_probe.peer_address;
                r_pport[0] <= i_probe.peer_port;
            end
            if (i_vld && w_add) begin
                for (int p = 0; p < PEERS; p++) begin
                    if (CW'(p) == r_cnt) begin
                        r_paddr[p] <= i_probe.peer_address;
                        r_pport[p] <= i_probe.peer_port;
                    end
                end
            end
        end
    end

    assign o_vld   = r_ovld;
    assign o_probe = r_oprobe;
    assign o_res   = r_ores;
    assign o_idx   = r_oidx;
    assign o_tot   = r_otot;

endmodule

>>> rtl/file_peer_registry_unit.sv
// file_peer_registry_unit: top level of the file peer registry.
// Depends on fpr_pkg, fpr_if and fpr_cell.
//
// One announcement at a time walks a row of TABLE_ENTRIES cells, one cell per
// clock unless the row stalls. Each cell owns one table slot: its 256-bit
// hash, chunk count, peer count and PEERS_PER_ENTRY peer address/port pairs.
// A cell holding the same hash settles the item (peer added, duplicate peer or
// list full); the first empty cell creates the entry there, since slots are
// only ever taken from the bottom up. An item that leaves the last cell
// unsettled reports table full. The result register follows the last cell.
// Ready stays low while an item is in the row, so the next item is taken only
// once the result has entered the result register.
// A finished result waits in the output register while the next item enters;
// only a second result meeting a full output register stalls the row.
// Reset empties every slot at once; no clearing pass is needed.
module file_peer_registry_unit #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int PEERS_PER_ENTRY = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpr_ann_if.sink    i_ann,
    fpr_res_if.source  o_res
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(PEERS_PER_ENTRY + 1);

    // hand-over signals between cells; element g feeds cell g
    logic             w_vld   [TABLE_ENTRIES+1];
    fpr_pkg::t_probe  w_probe [TABLE_ENTRIES+1];
    fpr_pkg::t_res    w_res   [TABLE_ENTRIES+1];
    logic [IW-1:0]    w_idx   [TABLE_ENTRIES+1];
    logic [CW-1:0]    w_tot   [TABLE_ENTRIES+1];

    logic             r_busy;
    logic             r_out_vld;
    fpr_pkg::t_status r_out_status;
    logic [fpr_pkg::INDEX_W-1:0] r_out_index;
    logic [fpr_pkg::TOTAL_W-1:0] r_out_total;

    logic             w_accept, w_adv, w_load;

    // input side: one item in the row at a time
    assign i_ann.ready = !r_busy;
    assign w_accept    = i_ann.valid && !r_busy;

    // row stalls only when its finished item cannot enter the output register
    assign w_load = w_vld[TABLE_ENTRIES] && (!r_out_vld || o_res.ready);
    assign w_adv  = !w_vld[TABLE_ENTRIES] || !r_out_vld || o_res.ready;

    assign w_vld[0]                = w_accept;
    assign w_probe[0].hash_word0   = i_ann.hash_word0;
    assign w_probe[0].hash_word1   = i_ann.hash_word1;
    assign w_probe[0].hash_word2   = i_ann.hash_word2;
    assign w_probe[0].hash_word3   = i_ann.hash_word3;
    assign w_probe[0].chunk_count  = i_ann.chunk_count;
    assign w_probe[0].peer_address = i_ann.peer_address;
    assign w_probe[0].peer_port    = i_ann.peer_port;
    assign w_res[0].done           = 1'b0;
    assign w_res[0].status         = fpr_pkg::ST_TABLE_FULL;
    assign w_idx[0]                = '0;
    assign w_tot[0]                = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        fpr_cell #(
            .CELL_IDX (g),
            .PEERS    (PEERS_PER_ENTRY),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[g]),
            .i_probe (w_probe[g]),
            .i_res   (w_res[g]),
            .i_idx   (w_idx[g]),
            .i_tot   (w_tot[g]),
            .o_vld   (w_vld[g+1]),
            .o_probe (w_probe[g+1]),
            .o_res   (w_res[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_tot   (w_tot[g+1])
        );
    end

    // busy from acceptance until the result lands in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // settled results copied; unsettled at row end: no match and no free slot
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_res[TABLE_ENTRIES].done) begin
                r_out_status <= w_res[TABLE_ENTRIES].status;
                r_out_index  <= fpr_pkg::INDEX_W'(w_idx[TABLE_ENTRIES]);
                r_out_total  <= fpr_pkg::TOTAL_W'(w_tot[TABLE_ENTRIES]);
            end else begin
                r_out_status <= fpr_pkg::ST_TABLE_FULL;
                r_out_index  <= '0;
                r_out_total  <= '0;
            end
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.status      = r_out_status;
    assign o_res.entry_index = r_out_index;
    assign o_res.peer_total  = r_out_total;

endmodule

>>> rtl/fpr_checker.sv
// fpr_checker: port-level checks on the file peer registry, bound to the top.
// Depends on fpr_pkg and file_peer_registry_unit.
module fpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic [fpr_pkg::STAT_W-1:0]    i_out_status,
    input logic [fpr_pkg::INDEX_W-1:0]   i_out_index,
    input logic [fpr_pkg::TOTAL_W-1:0]   i_out_total
);

    // one item in the row at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("fpr: ready held after accepting an item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= fpr_pkg::STAT_W'(fpr_pkg::ST_TABLE_FULL)))
        else $error("fpr: unknown status code");

    a_table_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == fpr_pkg::STAT_W'(fpr_pkg::ST_TABLE_FULL))
        |-> (i_out_index == '0 && i_out_total == '0))
        else $error("fpr: table full result carries index or peers");

    a_created_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == fpr_pkg::STAT_W'(fpr_pkg::ST_CREATED))
        |-> (i_out_total == fpr_pkg::TOTAL_W'(1)))
        else $error("fpr: new entry without exactly one peer");

endmodule

bind file_peer_registry_unit fpr_checker u_fpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_ann.valid),
    .i_in_ready   (i_ann.ready),
    .i_out_valid  (o_res.valid),
    .i_out_status (o_res.status),
    .i_out_index  (o_res.entry_index),
    .i_out_total  (o_res.peer_total)
);

>>> dv/fpr_registry_monitor.sv
// fpr_registry_monitor: watches the announcement and result channels of the
// file peer registry, keeps a shadow registry and checks every result.
// Depends on fpr_pkg and fpr_if.
`timescale 1ns / 1ps

module fpr_registry_monitor #(
    parameter int TABLE_ENTRIES   = 64,
    parameter int PEERS_PER_ENTRY = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fpr_ann_if   i_ann,
    fpr_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        fpr_pkg::t_status              status;
        logic [fpr_pkg::INDEX_W-1:0]   entry_index;
        logic [fpr_pkg::TOTAL_W-1:0]   peer_total;
    } t_outcome;

    // shadow copy of the registry
    logic                           slot_used  [TABLE_ENTRIES];
    logic [4*fpr_pkg::HASH_W-1:0]   slot_hash  [TABLE_ENTRIES];
    logic [fpr_pkg::CHUNK_W-1:0]    slot_chunks[TABLE_ENTRIES];
    int                             slot_peers [TABLE_ENTRIES];
    logic [fpr_pkg::ADDR_W-1:0]     slot_addr  [TABLE_ENTRIES][PEERS_PER_ENTRY];
    logic [fpr_pkg::PORT_W-1:0]     slot_port  [TABLE_ENTRIES][PEERS_PER_ENTRY];

    t_outcome outcome_q[$];

    // Applies one announcement to the shadow registry and returns its outcome.
    function automatic t_outcome register_announcement(input fpr_pkg::t_probe a);
        logic [4*fpr_pkg::HASH_W-1:0] key;
        int                           hit;
        int                           free;
        int                           n;
        bit                           listed;
        t_outcome                     r;
        key    = {a.hash_word3, a.hash_word2, a.hash_word1, a.hash_word0};
        hit    = -1;
        free   = -1;
        listed = 1'b0;
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (!slot_used[s]) begin
                if (free < 0) free = s;
            end else if (hit < 0 && slot_hash[s] == key) begin
                hit = s;
            end
        end
        if (hit >= 0) begin
            n = slot_peers[hit];
            r.entry_index = fpr_pkg::INDEX_W'(hit);
            // duplicate check comes first, so it wins over a full list
            for (int p = 0; p < n; p++) begin
                if (slot_addr[hit][p] == a.peer_address && slot_port[hit][p] == a.peer_port)
                    listed = 1'b1;
            end
            if (listed) begin
                r.status     = fpr_pkg::ST_DUPLICATE;
                r.peer_total = fpr_pkg::TOTAL_W'(n);
            end else if (n >= PEERS_PER_ENTRY) begin
                r.status     = fpr_pkg::ST_LIST_FULL;
                r.peer_total = fpr_pkg::TOTAL_W'(n);
            end else begin
                slot_addr[hit][n] = a.peer_address;
                slot_port[hit][n] = a.peer_port;
                slot_peers[hit]   = n + 1;
                r.status          = fpr_pkg::ST_ADDED;
                r.peer_total      = fpr_pkg::TOTAL_W'(n + 1);
            end
        end else if (free < 0) begin
            r.status      = fpr_pkg::ST_TABLE_FULL;
            r.entry_index = '0;
            r.peer_total  = '0;
        end else begin
            slot_used[free]    = 1'b1;
            slot_hash[free]    = key;
            slot_chunks[free]  = a.chunk_count;
            slot_addr[free][0] = a.peer_address;
            slot_port[free][0] = a.peer_port;
            slot_peers[free]   = 1;
            r.status           = fpr_pkg::ST_CREATED;
            r.entry_index      = fpr_pkg::INDEX_W'(free);
            r.peer_total       = fpr_pkg::TOTAL_W'(1);
        end
        return r;
    endfunction

    task automatic note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= SHOWN_MISMATCHES)
            $display("%0t: registry mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        fpr_pkg::t_probe a;
        t_outcome        want;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
                slot_used[s]   = 1'b0;
                slot_hash[s]   = '0;
                slot_chunks[s] = '0;
                slot_peers[s]  = 0;
            end
            outcome_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    note_failure($sformatf("result st=%0d idx=%0d peers=%0d, none outstanding",
                                           i_res.status, i_res.entry_index, i_res.peer_total));
                end else begin
                    want = outcome_q.pop_front();
                    if (i_res.status !== want.status ||
                        i_res.entry_index !== want.entry_index ||
                        i_res.peer_total !== want.peer_total)
                        note_failure($sformatf(
                            "exp st=%s idx=%0d peers=%0d, got st=%0d idx=%0d peers=%0d",
                            want.status.name(), want.entry_index, want.peer_total,
                            i_res.status, i_res.entry_index, i_res.peer_total));
                end
            end
            if (i_ann.valid && i_ann.ready) begin
                a.hash_word0   = i_ann.hash_word0;
                a.hash_word1   = i_ann.hash_word1;
                a.hash_word2   = i_ann.hash_word2;
                a.hash_word3   = i_ann.hash_word3;
                a.chunk_count  = i_ann.chunk_count;
                a.peer_address = i_ann.peer_address;
                a.peer_port    = i_ann.peer_port;
                outcome_q.push_back(register_announcement(a));
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

>>> dv/tb_file_peer_registry_unit.sv
// tb_file_peer_registry_unit: stimulus and verdict for the file peer registry.
// Depends on fpr_pkg, fpr_if, file_peer_registry_unit and fpr_registry_monitor.
`timescale 1ns / 1ps

module tb_file_peer_registry_unit;

    localparam int TABLE_ENTRIES    = 64;
    localparam int PEERS_PER_ENTRY  = 5;
    localparam int RANDOM_PER_PHASE = 460;   // three phases, about 1400 items in all
    localparam int PEER_POOL_SIZE   = 10;    // few peers, so lists fill and repeat
    localparam int HOLD_OFF_CYCLES  = 600;   // long receiver stall to back the row up
    localparam int DRAIN_CYCLES     = 80;    // a little over one trip through the row
    // Slowest honest gap between handshakes: one item's trip through the row,
    // a sender idle run and the hold-off below the row stall.
    // Several times that, comfortably.
    localparam int STALL_LIMIT      = 5000;

    localparam int HW = fpr_pkg::HASH_W;
    localparam int AW = fpr_pkg::ADDR_W;
    localparam int PW = fpr_pkg::PORT_W;
    localparam int KW = fpr_pkg::CHUNK_W;

    localparam logic [4*HW-1:0] HASH_ZERO = '0;
    localparam logic [4*HW-1:0] HASH_ONES = '1;
    localparam logic [HW-1:0]   WORD_ONES = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpr_ann_if ann_ch ();
    fpr_res_if res_ch ();

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_go;
    int quiet_cycles;

    // hashes already announced, and the peers that keep coming back
    logic [4*HW-1:0]    hash_pool[$];
    logic [AW+PW-1:0]   peer_pool[$];

    file_peer_registry_unit #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .PEERS_PER_ENTRY (PEERS_PER_ENTRY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ann   (ann_ch),
        .o_res   (res_ch)
    );

    fpr_registry_monitor #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .PEERS_PER_ENTRY (PEERS_PER_ENTRY)
    ) u_registry_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ann        (ann_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random back-pressure at the current idle rate. Once asked, it
    // holds ready low for a long stretch, counted here, while the sender keeps
    // offering, so the result register and then the row fill and the input stalls.
    initial begin : result_sink
        bit hold_off_done;
        hold_off_done = 1'b0;
        res_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_go && !hold_off_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (ann_ch.valid && ann_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [HW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic fpr_pkg::t_probe build_announcement(input logic [4*HW-1:0] h,
                                                           input logic [KW-1:0] chunks,
                                                           input logic [AW-1:0] addr,
                                                           input logic [PW-1:0] port);
        fpr_pkg::t_probe p;
        p.hash_word0   = h[HW-1:0];
        p.hash_word1   = h[2*HW-1:HW];
        p.hash_word2   = h[3*HW-1:2*HW];
        p.hash_word3   = h[4*HW-1:3*HW];
        p.chunk_count  = chunks;
        p.peer_address = addr;
        p.peer_port    = port;
        return p;
    endfunction

    // Mostly announcements of known files from known peers, so entries gather
    // peers, hit duplicates and fill their lists; now and then a fresh hash or
    // a one-bit near miss of a known one, which fills the table part way in.
    function automatic fpr_pkg::t_probe random_announcement();
        logic [4*HW-1:0]  h;
        logic [AW+PW-1:0] peer;
        int               roll;
        roll = $urandom_range(99);
        if (hash_pool.size() == 0 || roll < 6) begin
            h = {rand_word(), rand_word(), rand_word(), rand_word()};
            hash_pool.push_back(h);
        end else if (roll < 10) begin
            h = hash_pool[$urandom_range(hash_pool.size() - 1)];
            roll = $urandom_range(4*HW - 1);
            h[roll] = ~h[roll];
            hash_pool.push_back(h);
        end else begin
            h = hash_pool[$urandom_range(hash_pool.size() - 1)];
        end
        if ($urandom_range(3) != 0)
            peer = peer_pool[$urandom_range(peer_pool.size() - 1)];
        else
            peer = {$urandom, PW'($urandom)};
        return build_announcement(h, $urandom, peer[AW+PW-1:PW], peer[PW-1:0]);
    endfunction

    // Offers one item from a falling edge and returns at the falling edge
    // after it was taken. Valid stays high if the next item follows at once.
    task automatic send_announcement(input fpr_pkg::t_probe p);
        while ($urandom_range(99) < send_idle_pct) begin
            ann_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        ann_ch.valid        <= 1'b1;
        ann_ch.hash_word0   <= p.hash_word0;
        ann_ch.hash_word1   <= p.hash_word1;
        ann_ch.hash_word2   <= p.hash_word2;
        ann_ch.hash_word3   <= p.hash_word3;
        ann_ch.chunk_count  <= p.chunk_count;
        ann_ch.peer_address <= p.peer_address;
        ann_ch.peer_port    <= p.peer_port;
        do @(posedge i_clk); while (!(ann_ch.valid && ann_ch.ready));
        @(negedge i_clk);
    endtask

    task automatic announce(input logic [4*HW-1:0] h, input logic [KW-1:0] chunks,
                            input logic [AW-1:0] addr, input logic [PW-1:0] port);
        hash_pool.push_back(h);
        send_announcement(build_announcement(h, chunks, addr, port));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_announcement(random_announcement());
    endtask

    // Sender pause: nothing offered until every outstanding result is back.
    task automatic wait_all_resolved();
        ann_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        hold_off_go         = 1'b0;
        send_idle_pct       = 31;
        recv_idle_pct       = 67;
        ann_ch.valid        = 1'b0;
        ann_ch.hash_word0   = '0;
        ann_ch.hash_word1   = '0;
        ann_ch.hash_word2   = '0;
        ann_ch.hash_word3   = '0;
        ann_ch.chunk_count  = '0;
        ann_ch.peer_address = '0;
        ann_ch.peer_port    = '0;

        // peers that recur: the extremes first, the rest random
        peer_pool.push_back('0);
        peer_pool.push_back('1);
        peer_pool.push_back({{AW{1'b1}}, {PW{1'b0}}});
        peer_pool.push_back({{AW{1'b0}}, {PW{1'b1}}});
        while (peer_pool.size() < PEER_POOL_SIZE)
            peer_pool.push_back({$urandom, PW'($urandom)});

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Slot 0 gets the all-zero hash and is filled to its
        // limit; slot 1 the all-ones hash with every field at its maximum.
        announce(HASH_ZERO, '0, '0, '0);                    // created, slot 0
        announce(HASH_ONES, '1, '1, '1);                    // created, slot 1
        announce(HASH_ZERO, 32'd7, '1, '0);                 // added, address differs
        announce(HASH_ZERO, 32'd7, '0, '1);                 // added, only port differs
        announce(HASH_ZERO, 32'd9, '0, '0);                 // duplicate of first peer
        announce(HASH_ZERO, '1, 32'd1, 16'd1);              // added, fourth
        announce(HASH_ZERO, '0, 32'd2, 16'd2);              // added, list now full
        announce(HASH_ZERO, '0, 32'd3, 16'd3);              // new peer on a full list
        announce(HASH_ZERO, '0, '1, '0);                    // duplicate beats full list
        announce(HASH_ZERO, '0, 32'd2, 16'd2);              // duplicate in last slot
        // near misses of the all-ones hash: one word cleared at a time
        for (int w = 0; w < 4; w++)
            announce(HASH_ONES & ~({{(3*HW){1'b0}}, WORD_ONES} << (HW * w)),
                     32'($urandom), '1, '1);
        announce(HASH_ONES, 32'd5, '1, '1);                 // duplicate, chunk ignored
        announce(HASH_ONES, 32'd5, '1, 16'hFFFE);           // added, port off by one
        announce({1'b1, {(4*HW-1){1'b0}}}, 32'h8000_0000, 32'h8000_0000, 16'h8000);
        announce({{(4*HW-1){1'b0}}, 1'b1}, 32'd1, 32'd1, 16'd0);

        // Phase one: slow receiver.
        send_random(RANDOM_PER_PHASE);
        wait_all_resolved();

        // Phase two: slow sender.
        send_idle_pct = 67;
        recv_idle_pct = 31;
        send_random(RANDOM_PER_PHASE);
        wait_all_resolved();

        // Phase three: no idling, opened by the long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_go   = 1'b1;
        send_random(RANDOM_PER_PHASE);
        wait_all_resolved();

        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fpr_pkg.sv
rtl/fpr_if.sv
rtl/fpr_cell.sv
rtl/file_peer_registry_unit.sv
rtl/fpr_checker.sv
dv/fpr_registry_monitor.sv
dv/tb_file_peer_registry_unit.sv
